/* rtl/sbp_pkg.sv */
// Shared constants, status codes and a helper function of the size class buffer pool.
`timescale 1ns / 1ps

package sbp_pkg;

  // Pool geometry.
  localparam int NUM_CLASSES       = 4;
  localparam int PER_CLASS_BUFFERS = 64;

  // Field widths.
  localparam int LEN_W    = 16;
  localparam int HANDLE_W = 8;
  localparam int STATUS_W = 3;
  localparam int CLS_W    = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int SLOT_W   = (PER_CLASS_BUFFERS > 1) ? $clog2(PER_CLASS_BUFFERS) : 1;
  localparam int CNT_W    = $clog2(PER_CLASS_BUFFERS + 1);
  localparam int HCLS_W   = HANDLE_W - SLOT_W;
  localparam int ADDR_W   = CLS_W + SLOT_W;
  localparam int STACK_ENTRIES = NUM_CLASSES * (2 ** SLOT_W);

  // Configuration port.
  localparam int NUM_REGS   = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = LEN_W;

  // Operation codes.
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_REUSED    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_CREATED   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_TOO_LONG  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FREED     = 3'd4;
  localparam logic [STATUS_W-1:0] ST_REJECTED  = 3'd5;

  // Reset capacity of each class; classes past the fourth have no register and stay at zero.
  function automatic logic [LEN_W-1:0] class_len_reset(input int k);
    logic [LEN_W-1:0] v;
    case (k)
      0: v = 16'd64;
      1: v = 16'd256;
      2: v = 16'd1024;
      3: v = 16'd4096;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

/* rtl/sbp_if.sv */
// Valid/ready channel interfaces for requests into and results out of the buffer pool.
`timescale 1ns / 1ps

interface sbp_req_if;
  logic                          valid;
  logic                          ready;
  logic                          opcode;
  logic [sbp_pkg::LEN_W-1:0]     request_length;
  logic [sbp_pkg::HANDLE_W-1:0]  handle_in;

  modport source (output valid, opcode, request_length, handle_in, input ready);
  modport sink   (input valid, opcode, request_length, handle_in, output ready);
endinterface

interface sbp_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [sbp_pkg::STATUS_W-1:0]  status;
  logic [sbp_pkg::HANDLE_W-1:0]  handle_out;
  logic [1:0]                    class_index;
  logic [6:0]                    class_in_use;

  modport source (output valid, status, handle_out, class_index, class_in_use, input ready);
  modport sink   (input valid, status, handle_out, class_index, class_in_use, output ready);
endinterface

/* rtl/size_class_buffer_pool.sv */
// Top level of the size class buffer pool: class search, counters and free-stack memory.
`timescale 1ns / 1ps
// A request is accepted in S_IDLE; its result enters the output register in S_READ
// once that register is free, and no new request is taken before then, since a pop's
// slot is known only the cycle after the request, from the registered stack read.
// Reset (synchronous, rst_n low): class lengths return to 64/256/1024/4096 bytes, all
// per-class counters clear and the channels go idle. The free-stack memory is not cleared;
// an entry is only popped after a free has written it.

module size_class_buffer_pool (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [sbp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sbp_pkg::CFG_DATA_W-1:0]  cfg_data,
  sbp_req_if.sink                         in_ch,
  sbp_rsp_if.source                       out_ch
);

  typedef enum logic {S_IDLE, S_READ} state_t;

  // Class lengths and per-class counters live in flip-flops; only four of each.
  logic [sbp_pkg::LEN_W-1:0] len_r     [sbp_pkg::NUM_CLASSES];
  logic [sbp_pkg::CNT_W-1:0] depth_r   [sbp_pkg::NUM_CLASSES];
  logic [sbp_pkg::CNT_W-1:0] created_r [sbp_pkg::NUM_CLASSES];
  logic [sbp_pkg::CNT_W-1:0] in_use_r  [sbp_pkg::NUM_CLASSES];

  // The free stacks of all classes share one memory, addressed by class and stack position.
  logic [sbp_pkg::SLOT_W-1:0] stack_mem [sbp_pkg::STACK_ENTRIES];
  logic [sbp_pkg::SLOT_W-1:0] mem_rdata_r;
  logic                       mem_we, mem_re;
  logic [sbp_pkg::ADDR_W-1:0] mem_addr;
  logic [sbp_pkg::SLOT_W-1:0] mem_wdata;

  state_t state_r;

  // Result held while the memory read completes.
  logic [sbp_pkg::STATUS_W-1:0] pend_status_r;
  logic [sbp_pkg::HANDLE_W-1:0] pend_handle_r;
  logic [sbp_pkg::CLS_W-1:0]    pend_cls_r;
  logic [sbp_pkg::CNT_W-1:0]    pend_in_use_r;
  logic                         pend_pop_r;

  // Output register, which parts the result channel from the request side.
  logic                         out_valid_r;
  logic [sbp_pkg::STATUS_W-1:0] out_status_r;
  logic [sbp_pkg::HANDLE_W-1:0] out_handle_r;
  logic [sbp_pkg::CLS_W-1:0]    out_cls_r;
  logic [sbp_pkg::CNT_W-1:0]    out_in_use_r;

  logic accept;
  logic out_free;

  // Decision for the request on the input channel.
  logic                         alloc_hit;
  logic [sbp_pkg::CLS_W-1:0]    alloc_cls;
  logic [sbp_pkg::HCLS_W-1:0]   free_hcls;
  logic [sbp_pkg::SLOT_W-1:0]   free_slot;
  logic                         free_cls_ok;
  logic [sbp_pkg::CLS_W-1:0]    sel_cls;
  logic [sbp_pkg::CNT_W-1:0]    sel_depth, sel_created, sel_in_use;
  logic [sbp_pkg::STATUS_W-1:0] dec_status;
  logic [sbp_pkg::HANDLE_W-1:0] dec_handle;
  logic [sbp_pkg::CLS_W-1:0]    dec_cls;
  logic [sbp_pkg::CNT_W-1:0]    dec_in_use;
  logic [sbp_pkg::CNT_W-1:0]    depth_nxt, created_nxt, in_use_nxt;
  logic                         upd_cnt;

  assign accept   = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;

  assign in_ch.ready        = (state_r == S_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.handle_out  = out_handle_r;
  assign out_ch.class_index = 2'(out_cls_r);
  assign out_ch.class_in_use = 7'(out_in_use_r);

  // First class in index order whose length covers the request.
  always_comb begin
    alloc_hit = 1'b0;
    alloc_cls = '0;
    for (int k = sbp_pkg::NUM_CLASSES - 1; k >= 0; k--) begin
      if (in_ch.request_length <= len_r[k]) begin
        alloc_hit = 1'b1;
        alloc_cls = sbp_pkg::CLS_W'(k);
      end
    end
  end

  // A handle carries its class in the upper bits and its slot in the lower bits.
  assign free_hcls   = in_ch.handle_in[sbp_pkg::HANDLE_W-1:sbp_pkg::SLOT_W];
  assign free_slot   = in_ch.handle_in[sbp_pkg::SLOT_W-1:0];
  assign free_cls_ok = (int'(free_hcls) < sbp_pkg::NUM_CLASSES);

  assign sel_cls     = (in_ch.opcode == sbp_pkg::OP_FREE) ? sbp_pkg::CLS_W'(free_hcls)
                                                          : alloc_cls;
  assign sel_depth   = depth_r[sel_cls];
  assign sel_created = created_r[sel_cls];
  assign sel_in_use  = in_use_r[sel_cls];

  always_comb begin
    dec_status  = sbp_pkg::ST_REJECTED;
    dec_handle  = '0;
    dec_cls     = '0;
    dec_in_use  = '0;
    depth_nxt   = sel_depth;
    created_nxt = sel_created;
    in_use_nxt  = sel_in_use;
    upd_cnt     = 1'b0;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_addr    = {sel_cls, sel_depth[sbp_pkg::SLOT_W-1:0]};
    mem_wdata   = free_slot;
    if (in_ch.opcode == sbp_pkg::OP_ALLOC) begin
      if (!alloc_hit) begin
        dec_status = sbp_pkg::ST_TOO_LONG;
      end else if (sel_depth != '0) begin
        // Pop: the slot comes from the top of the class's stack next cycle.
        depth_nxt  = sel_depth - 1'b1;
        in_use_nxt = sel_in_use + 1'b1;
        upd_cnt    = 1'b1;
        mem_re     = accept;
        mem_addr   = {sel_cls, depth_nxt[sbp_pkg::SLOT_W-1:0]};
        dec_status = sbp_pkg::ST_REUSED;
        dec_cls    = sel_cls;
        dec_in_use = in_use_nxt;
      end else if (int'(sel_created) < sbp_pkg::PER_CLASS_BUFFERS) begin
        created_nxt = sel_created + 1'b1;
        in_use_nxt  = sel_in_use + 1'b1;
        upd_cnt     = 1'b1;
        dec_status  = sbp_pkg::ST_CREATED;
        dec_handle  = sbp_pkg::HANDLE_W'(int'(sel_cls) * sbp_pkg::PER_CLASS_BUFFERS)
                    + sbp_pkg::HANDLE_W'(sel_created);
        dec_cls     = sel_cls;
        dec_in_use  = in_use_nxt;
      end else begin
        dec_status = sbp_pkg::ST_EXHAUSTED;
        dec_cls    = sel_cls;
        dec_in_use = sel_in_use;
      end
    end else begin
      if (!free_cls_ok) begin
        dec_status = sbp_pkg::ST_REJECTED;
      end else if ((sel_in_use == '0) ||
                   (int'(sel_depth) >= sbp_pkg::PER_CLASS_BUFFERS)) begin
        // Nothing of this class is out, or its stack is full: the free changes nothing.
        dec_status = sbp_pkg::ST_REJECTED;
        dec_cls    = sel_cls;
        dec_in_use = sel_in_use;
      end else begin
        depth_nxt  = sel_depth + 1'b1;
        in_use_nxt = sel_in_use - 1'b1;
        upd_cnt    = 1'b1;
        mem_we     = accept;
        dec_status = sbp_pkg::ST_FREED;
        dec_cls    = sel_cls;
        dec_in_use = in_use_nxt;
      end
    end
  end

  // Configuration registers and per-class counters.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < sbp_pkg::NUM_CLASSES; k++) begin
        len_r[k]     <= sbp_pkg::class_len_reset(k);
        depth_r[k]   <= '0;
        created_r[k] <= '0;
        in_use_r[k]  <= '0;
      end
    end else begin
      for (int k = 0; k < sbp_pkg::NUM_CLASSES; k++) begin
        if (cfg_we && (int'(cfg_index) == k) && (k < sbp_pkg::NUM_REGS)) begin
          len_r[k] <= cfg_data;
        end
      end
      if (accept && upd_cnt) begin
        depth_r[sel_cls]   <= depth_nxt;
        created_r[sel_cls] <= created_nxt;
        in_use_r[sel_cls]  <= in_use_nxt;
      end
    end
  end

  // Free-stack memory; the read data register holds until the next pop.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      stack_mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_r <= stack_mem[mem_addr];
    end
  end

  // Sequencer and output register. A request is taken in S_IDLE; in S_READ the popped
  // slot is available and the result moves to the output register once it is free.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            pend_status_r <= dec_status;
            pend_handle_r <= dec_handle;
            pend_cls_r    <= dec_cls;
            pend_in_use_r <= dec_in_use;
            pend_pop_r    <= mem_re;
            state_r       <= S_READ;
          end
        end
        S_READ: begin
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_status_r <= pend_status_r;
            out_handle_r <= pend_pop_r
                          ? sbp_pkg::HANDLE_W'(int'(pend_cls_r) * sbp_pkg::PER_CLASS_BUFFERS)
                            + sbp_pkg::HANDLE_W'(mem_rdata_r)
                          : pend_handle_r;
            out_cls_r    <= pend_cls_r;
            out_in_use_r <= pend_in_use_r;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // Every created handle is either on its class's stack or handed out.
  for (genvar g = 0; g < sbp_pkg::NUM_CLASSES; g++) begin : g_chk
    a_conservation: assert property (@(posedge clk) disable iff (!rst_n)
      ({1'b0, depth_r[g]} + {1'b0, in_use_r[g]}) == {1'b0, created_r[g]})
      else $error("class %0d: stack depth plus in-use differs from created count", g);
    a_created_bound: assert property (@(posedge clk) disable iff (!rst_n)
      int'(created_r[g]) <= sbp_pkg::PER_CLASS_BUFFERS)
      else $error("class %0d: more handles created than the class holds", g);
  end

  a_handle_class: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && ((out_status_r == sbp_pkg::ST_REUSED) ||
                     (out_status_r == sbp_pkg::ST_CREATED)))
    |-> (int'(out_handle_r) / sbp_pkg::PER_CLASS_BUFFERS == int'(out_cls_r)))
    else $error("allocated handle does not encode its class");

  a_no_handle_on_free: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && ((out_status_r == sbp_pkg::ST_FREED) ||
                     (out_status_r == sbp_pkg::ST_REJECTED) ||
                     (out_status_r == sbp_pkg::ST_TOO_LONG)))
    |-> (out_handle_r == '0))
    else $error("handle given on a result that hands out no buffer");

  a_pop_read: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && mem_re) |=> (state_r == S_READ) && pend_pop_r)
    else $error("pop issued without a pending read result");

endmodule
